[hw/rtl/lnt_pkg.sv]
// Shared types and constants for the lattice noise turbulence block.
// No dependencies.
package lnt_pkg;

    localparam int HASH_ENTRIES = 4096;
    localparam int GRAD_ENTRIES = 512;
    localparam int MAX_OCTAVES  = 8;
    localparam int HASH_AW      = $clog2(HASH_ENTRIES);
    localparam int GRAD_AW      = $clog2(GRAD_ENTRIES);

    localparam int MUL_A_W = 19;
    localparam int MUL_B_W = 36;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    typedef enum logic [1:0] {
        OP_WR_HASH = 2'd0,
        OP_WR_GRAD = 2'd1,
        OP_SCALAR  = 2'd2,
        OP_VECTOR  = 2'd3
    } lnt_op_t;

    typedef enum logic [1:0] {
        CFG_OFFSET_X = 2'd0,
        CFG_OFFSET_Y = 2'd1,
        CFG_OFFSET_Z = 2'd2
    } lnt_cfg_t;

    typedef struct packed {
        lnt_op_t            op;
        logic [11:0]        table_index;
        logic [11:0]        hash_value;
        logic signed [15:0] gradient_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [3:0]         octaves;
    } lnt_in_t;

    typedef struct packed {
        logic signed [19:0] value_x;
        logic signed [19:0] value_y;
        logic signed [19:0] value_z;
    } lnt_out_t;

    typedef struct packed {
        logic [2:0][31:0] off;
    } lnt_offs_t;

    typedef struct packed {
        logic start;
        logic slot_free;
    } lnt_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } lnt_stat_t;

endpackage

[hw/rtl/lnt_mul.sv]
// Shared signed multiplier with registered product.
// Depends on lnt_pkg.
module lnt_mul
    import lnt_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [PROD_W-1:0]  prod_reg
);

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

endmodule

[hw/rtl/lnt_core.sv]
// Noise sequencer: lattice split, smoothstep, hashing, gradient dot products.
// Holds both lookup tables. Depends on lnt_pkg and lnt_mul.
module lnt_core
    import lnt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  lnt_ctl_t  ctl,
    input  lnt_in_t   item,
    input  lnt_offs_t offs,
    output lnt_stat_t stat,
    output lnt_out_t  result
);

    typedef enum logic [18:0] {
        ST_IDLE  = 19'h00001,
        ST_SPLIT = 19'h00002,
        ST_SQ    = 19'h00004,
        ST_CUBE  = 19'h00008,
        ST_SPW   = 19'h00010,
        ST_W01   = 19'h00020,
        ST_W2    = 19'h00040,
        ST_H2    = 19'h00080,
        ST_H3    = 19'h00100,
        ST_GA    = 19'h00200,
        ST_GB    = 19'h00400,
        ST_GC    = 19'h00800,
        ST_GD    = 19'h01000,
        ST_GE    = 19'h02000,
        ST_GF    = 19'h04000,
        ST_GM    = 19'h08000,
        ST_GACC  = 19'h10000,
        ST_OCT   = 19'h20000,
        ST_DONE  = 19'h40000
    } lnt_state_t;

    lnt_state_t state_reg, state_next;
    logic [1:0] ax_reg, ax_next;
    logic [2:0] corner_reg, corner_next;
    logic [1:0] comp_reg, comp_next;
    logic [3:0] oct_reg, oct_next;
    logic [3:0] oct_lim_reg, oct_lim_next;

    logic              vec_reg;
    logic [2:0][31:0]  p_reg;
    logic [2:0][11:0]  cell_reg;
    logic [2:0][15:0]  t_reg;
    logic [2:0][15:0]  sp_reg;
    logic [16:0]       wt_reg;
    logic [7:0]        m_reg;
    logic signed [34:0] inner_reg;
    logic signed [51:0] acc_reg [3];
    logic signed [23:0] res_reg [3];

    logic [11:0]         perm_mem [HASH_ENTRIES];
    logic [15:0]         grad_mem [GRAD_ENTRIES];
    logic [11:0]         perm_rd_reg;
    logic signed [15:0]  grad_rd_reg;
    logic [HASH_AW-1:0]  perm_addr;
    logic [GRAD_AW-1:0]  grad_addr;
    logic [GRAD_AW-1:0]  grad_base;
    logic                perm_we;
    logic                grad_we;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    logic [2:0][11:0] corner_addr;
    logic [2:0][16:0] w;
    logic [2:0][16:0] d;
    logic [2:0][27:0] v;
    logic             start_noise;
    logic [3:0]       oct_in;

    lnt_mul u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    function automatic logic signed [19:0] sat20(input logic signed [23:0] x);
        logic signed [19:0] r;
        if (x > 24'sd524287)
            r = 20'sh7FFFF;
        else if (x < -24'sd524288)
            r = 20'sh80000;
        else
            r = x[19:0];
        return r;
    endfunction

    assign start_noise = ctl.start && (item.op == OP_SCALAR || item.op == OP_VECTOR);
    assign oct_in = (item.octaves > 4'(MAX_OCTAVES)) ? 4'(MAX_OCTAVES) : item.octaves;
    assign perm_we = ctl.start && (item.op == OP_WR_HASH);
    assign grad_we = ctl.start && (item.op == OP_WR_GRAD)
                     && (item.table_index < 12'(GRAD_ENTRIES));

    always_comb
    begin
        logic [31:0] psh;
        for (int k = 0; k < 3; k++)
        begin
            psh = p_reg[k] << oct_reg[2:0];
            v[k] = psh[27:0] - offs.off[k][27:0];
            corner_addr[k] = corner_reg[k] ? cell_reg[k] + 12'd1 : cell_reg[k];
            w[k] = corner_reg[k] ? {1'b0, sp_reg[k]} : 17'h10000 - {1'b0, sp_reg[k]};
            d[k] = {corner_reg[k], t_reg[k]};
        end
    end

    assign grad_base = GRAD_AW'({1'b0, m_reg}) + GRAD_AW'({comp_reg, 2'b00});

    always_comb
    begin
        perm_addr = '0;
        grad_addr = grad_base;
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SQ:
            begin
                mul_a = MUL_A_W'(t_reg[ax_reg]);
                mul_b = MUL_B_W'(t_reg[ax_reg]);
            end
            ST_CUBE:
            begin
                mul_a = 19'd196608 - {2'b00, t_reg[ax_reg], 1'b0};
                mul_b = MUL_B_W'(prod[31:0]);
            end
            ST_W01:
            begin
                mul_a = MUL_A_W'(w[0]);
                mul_b = MUL_B_W'(w[1]);
                perm_addr = corner_addr[0];
            end
            ST_W2:
            begin
                mul_a = MUL_A_W'(w[2]);
                mul_b = MUL_B_W'(prod[32:16]);
                perm_addr = perm_rd_reg ^ corner_addr[1];
            end
            ST_H2:   perm_addr = perm_rd_reg ^ corner_addr[2];
            ST_GB:   grad_addr = grad_base + GRAD_AW'(1);
            ST_GC:
            begin
                grad_addr = grad_base + GRAD_AW'(2);
                mul_a = MUL_A_W'($signed(d[0]));
                mul_b = MUL_B_W'(grad_rd_reg);
            end
            ST_GD:
            begin
                grad_addr = grad_base + GRAD_AW'(3);
                mul_a = MUL_A_W'($signed(d[1]));
                mul_b = MUL_B_W'(grad_rd_reg);
            end
            ST_GE:
            begin
                mul_a = MUL_A_W'($signed(d[2]));
                mul_b = MUL_B_W'(grad_rd_reg);
            end
            ST_GM:
            begin
                mul_a = MUL_A_W'(wt_reg);
                mul_b = MUL_B_W'(inner_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        ax_next = ax_reg;
        corner_next = corner_reg;
        comp_next = comp_reg;
        oct_next = oct_reg;
        oct_lim_next = oct_lim_reg;
        unique case (state_reg)
            ST_IDLE:
                if (start_noise)
                begin
                    oct_next = '0;
                    oct_lim_next = oct_in;
                    state_next = (oct_in == 4'd0) ? ST_DONE : ST_SPLIT;
                end
            ST_SPLIT:
            begin
                ax_next = '0;
                state_next = ST_SQ;
            end
            ST_SQ:   state_next = ST_CUBE;
            ST_CUBE: state_next = ST_SPW;
            ST_SPW:
                if (ax_reg == 2'd2)
                begin
                    corner_next = '0;
                    state_next = ST_W01;
                end
                else
                begin
                    ax_next = ax_reg + 2'd1;
                    state_next = ST_SQ;
                end
            ST_W01:  state_next = ST_W2;
            ST_W2:   state_next = ST_H2;
            ST_H2:   state_next = ST_H3;
            ST_H3:
            begin
                comp_next = '0;
                state_next = ST_GA;
            end
            ST_GA:   state_next = ST_GB;
            ST_GB:   state_next = ST_GC;
            ST_GC:   state_next = ST_GD;
            ST_GD:   state_next = ST_GE;
            ST_GE:   state_next = ST_GF;
            ST_GF:   state_next = ST_GM;
            ST_GM:   state_next = ST_GACC;
            ST_GACC:
                if (vec_reg && comp_reg != 2'd2)
                begin
                    comp_next = comp_reg + 2'd1;
                    state_next = ST_GA;
                end
                else if (corner_reg != 3'd7)
                begin
                    corner_next = corner_reg + 3'd1;
                    state_next = ST_W01;
                end
                else
                    state_next = ST_OCT;
            ST_OCT:
            begin
                oct_next = oct_reg + 4'd1;
                state_next = (oct_reg + 4'd1 == oct_lim_reg) ? ST_DONE : ST_SPLIT;
            end
            ST_DONE:
                if (ctl.slot_free)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ax_reg <= '0;
            corner_reg <= '0;
            comp_reg <= '0;
            oct_reg <= '0;
            oct_lim_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ax_reg <= ax_next;
            corner_reg <= corner_next;
            comp_reg <= comp_next;
            oct_reg <= oct_next;
            oct_lim_reg <= oct_lim_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (perm_we)
            perm_mem[item.table_index] <= item.hash_value;
        perm_rd_reg <= perm_mem[perm_addr];
    end

    always_ff @(posedge clk)
    begin
        if (grad_we)
            grad_mem[item.table_index[GRAD_AW-1:0]] <= item.gradient_value;
        grad_rd_reg <= grad_mem[grad_addr];
    end

    always_ff @(posedge clk)
    begin
        logic signed [20:0] n;
        logic signed [21:0] s;
        logic [16:0]        sc;
        unique case (state_reg) inside
            ST_IDLE:
                if (start_noise)
                begin
                    vec_reg <= (item.op == OP_VECTOR);
                    p_reg <= {item.point_z, item.point_y, item.point_x};
                    for (int k = 0; k < 3; k++)
                        res_reg[k] <= '0;
                end
            ST_SPLIT:
                for (int k = 0; k < 3; k++)
                begin
                    cell_reg[k] <= v[k][27:16];
                    t_reg[k] <= v[k][15:0];
                    acc_reg[k] <= '0;
                end
            ST_SPW:  sp_reg[ax_reg] <= prod[47:32];
            ST_H2:   wt_reg <= prod[32:16];
            ST_H3:   m_reg <= perm_rd_reg[7:0];
            ST_GB:   inner_reg <= 35'(grad_rd_reg) <<< 15;
            ST_GD, ST_GE, ST_GF: inner_reg <= inner_reg + prod[34:0];
            ST_GACC: acc_reg[comp_reg] <= acc_reg[comp_reg] + prod[51:0];
            ST_OCT:
                if (!vec_reg)
                begin
                    n = acc_reg[0][51:31];
                    s = 22'(n) + 22'sd32768;
                    if (s < 22'sd0)
                        sc = '0;
                    else if (s > 22'sd65536)
                        sc = 17'h10000;
                    else
                        sc = s[16:0];
                    res_reg[0] <= res_reg[0] + 24'(sc >> oct_reg[2:0]);
                end
                else
                    for (int k = 0; k < 3; k++)
                    begin
                        n = acc_reg[k][51:31];
                        res_reg[k] <= res_reg[k] + 24'(n >>> oct_reg[2:0]);
                    end
            default:
            begin
            end
        endcase
    end

    assign stat.busy = (state_reg != ST_IDLE);
    assign stat.done = (state_reg == ST_DONE) && ctl.slot_free;
    assign result.value_x = sat20(res_reg[0]);
    assign result.value_y = sat20(res_reg[1]);
    assign result.value_z = sat20(res_reg[2]);

endmodule

[hw/rtl/lattice_noise_turbulence.sv]
// Lattice gradient noise with octave summing; a write word loads a table entry.
// Per octave: split and smoothstep, then hash and gradient steps for all eight corners,
// one gradient pass per component (1 scalar, 3 vector), paced by the single shared
// multiplier and one read port per table. One word at a time; zero octaves go to done.
// Reset clears control and offsets; table contents are undefined until written.
module lattice_noise_turbulence
    import lnt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  lnt_in_t     sample_word,
    output logic        result_valid,
    input  logic        result_stall,
    output lnt_out_t    result_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    lnt_offs_t offs_reg;
    logic      result_valid_reg;
    lnt_out_t  result_word_reg;
    lnt_ctl_t  ctl;
    lnt_stat_t stat;
    lnt_out_t  core_result;

    assign cfg_ready = 1'b1;
    assign sample_stall = stat.busy;
    assign ctl.start = sample_valid && !sample_stall;
    assign ctl.slot_free = !result_valid_reg;

    lnt_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .item   (sample_word),
        .offs   (offs_reg),
        .stat   (stat),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            offs_reg <= '0;
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_OFFSET_X: offs_reg.off[0] <= cfg_data;
                CFG_OFFSET_Y: offs_reg.off[1] <= cfg_data;
                CFG_OFFSET_Z: offs_reg.off[2] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (stat.done)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (stat.done)
            result_word_reg <= core_result;
    end

    assign result_valid = result_valid_reg;
    assign result_word = result_word_reg;

    a_done_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> !result_valid_reg)
        else $error("result produced while output word still pending");

    a_noise_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.start && (sample_word.op == OP_SCALAR || sample_word.op == OP_VECTOR))
        |=> stat.busy)
        else $error("noise word accepted but sequencer stayed idle");

    a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.start && (sample_word.op == OP_WR_HASH || sample_word.op == OP_WR_GRAD))
        |=> !stat.busy && !stat.done)
        else $error("table write started a computation");

endmodule
